[rtl/assert_macros.svh]
// assertion macros shared by the allocator modules
// no dependencies; assertions drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked at every clock edge outside reset
`define BPA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// checked at every clock edge, reset included
`define BPA_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define BPA_ASSERT(lbl, clk, rst, prop)
`define BPA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[rtl/bpa_pkg.sv]
// shared types and constants of the bitmap page allocator
// no dependencies
`timescale 1ns / 1ps
package bpa_pkg;
   localparam int WORD_BITS   = 64;
   localparam int WORD_LOG    = 6;
   localparam int LANE_BITS   = 8;
   localparam int LANE_LOG    = 3;
   localparam int CNT_FIELD_W = 13;
   localparam int CSR_AW      = 4;
   localparam int CSR_IDX_BIT = 3;

   localparam logic REG_BASE = 1'b0;
   localparam logic REG_SIZE = 1'b1;

   typedef enum logic [1:0] {
      CMD_ALLOC       = 2'd0,
      CMD_ALLOC_ALIGN = 2'd1,
      CMD_FREE        = 2'd2
   } cmd_type;

   typedef struct packed {
      logic clear_init;
      logic clear_wr;
      logic load;
      logic prep;
      logic check;
      logic scan_init;
      logic scan_rd;
      logic scan_step;
      logic mark_rd;
      logic mark_wr;
      logic rsp_load;
      logic rsp_ok;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic go;
      logic go_free;
      logic scan_hit;
      logic scan_end;
      logic scan_lane_last;
      logic mark_last;
   } dp_status_type;
endpackage

[rtl/bpa_if.sv]
// valid/ready channel interfaces for allocator requests and results
// no dependencies
`timescale 1ns / 1ps
interface bpa_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [12:0] page_count;
   logic [5:0]  align_shift;
   logic [63:0] free_addr;
   modport source (output valid, command, page_count, align_shift, free_addr, input ready);
   modport sink (input valid, command, page_count, align_shift, free_addr, output ready);
endinterface

interface bpa_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [63:0] alloc_addr;
   logic [12:0] pages_free;
   modport source (output valid, ok, alloc_addr, pages_free, input ready);
   modport sink (input valid, ok, alloc_addr, pages_free, output ready);
endinterface

[rtl/bpa_ram.sv]
// generic single write port ram with one registered read port
// no dependencies
`timescale 1ns / 1ps
module bpa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/bpa_ctrl.sv]
// sequencer of the allocator: clear sweep, request check, scan, mark, result
// depends on bpa_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bpa_ctrl import bpa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          clear_start,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);
   typedef enum logic [8:0] {
      ST_CLEAR   = 9'b000000001,
      ST_IDLE    = 9'b000000010,
      ST_PREP    = 9'b000000100,
      ST_CHECK   = 9'b000001000,
      ST_SCAN_RD = 9'b000010000,
      ST_SCAN    = 9'b000100000,
      ST_MARK_RD = 9'b001000000,
      ST_MARK_WR = 9'b010000000,
      ST_DONE    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      ok_ff, ok_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE) && !clear_start;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      ok_in    = ok_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            if (!status.go) begin
               ok_in    = 1'b0;
               state_in = ST_DONE;
            end else if (status.go_free) begin
               state_in = ST_MARK_RD;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            cmd.scan_rd = 1'b1;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_hit) begin
               state_in = ST_MARK_RD;
            end else if (status.scan_end) begin
               ok_in    = 1'b0;
               state_in = ST_DONE;
            end else if (status.scan_lane_last) begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_MARK_RD: begin
            cmd.mark_rd = 1'b1;
            state_in    = ST_MARK_WR;
         end
         ST_MARK_WR: begin
            cmd.mark_wr = 1'b1;
            if (status.mark_last) begin
               ok_in    = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_MARK_RD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
      cmd.rsp_ok = ok_ff;
      if (clear_start) begin
         cmd.clear_init = 1'b1;
         state_in       = ST_CLEAR;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ok_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ok_ff        <= ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `BPA_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (state_ff == ST_CLEAR))
   `BPA_ASSERT(a_accept_to_prep, clock, reset, (accept && !clear_start) |=> (state_ff == ST_PREP))
   `BPA_ASSERT(a_load_slot_free, clock, reset, cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
endmodule

[rtl/bpa_dpath.sv]
// allocator datapath: heap state, bitmap ram, request checks, run scan, marking
// depends on bpa_pkg, bpa_ram and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bpa_dpath import bpa_pkg::*; #(
   parameter int MAX_PAGES  = 4096,
   parameter int PAGE_SHIFT = 12,
   parameter int MIN_PAGES  = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   input  logic [63:0]   base_addr,
   input  logic          size_wr,
   input  logic [63:0]   size_value,
   input  logic [1:0]    req_command,
   input  logic [12:0]   req_page_count,
   input  logic [5:0]    req_align_shift,
   input  logic [63:0]   req_free_addr,
   output logic          rsp_ok,
   output logic [63:0]   rsp_alloc_addr,
   output logic [12:0]   rsp_pages_free
);
   localparam int PW   = $clog2(MAX_PAGES + 1);
   localparam int CW   = (PW > CNT_FIELD_W) ? PW : CNT_FIELD_W;
   localparam int CW1  = CW + 1;
   localparam int ROWS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int PB   = 64 - PAGE_SHIFT;
   localparam logic [RAW-1:0] LAST_ROW = RAW'(ROWS - 1);
   localparam logic [5:0]     PS6      = 6'(PAGE_SHIFT);

   // heap state
   logic [CW-1:0] usable_ff, free_ff;
   logic          ready_ff;
   // latched request
   logic [1:0]    cmd_ff;
   logic [CW-1:0] count_ff;
   logic [5:0]    shift_ff;
   logic [63:0]   faddr_ff;
   // precomputed terms
   logic [63:0]   diff_ff;
   logic          ge_ff;
   logic [PB-1:0] nb_ff;
   logic          balign_ff;
   logic [CW-1:0] t_ff, lmask_ff;
   logic          pre_ok_ff;
   // scan and mark
   logic [CW-1:0]  p_ff, c_ff, len_ff, ms_ff;
   logic           have_ff;
   logic [RAW-1:0] r_ff;
   // result
   logic          ok_ff;
   logic [63:0]   addr_ff;
   logic [12:0]   pf_ff;

   logic [WORD_BITS-1:0] rd_data, wr_data, merged, mask;
   logic                 ram_wr, ram_rd;
   logic [RAW-1:0]       rd_addr;

   // ---- check terms
   logic [CW-1:0] idx;
   logic [CW1-1:0] idx_end;
   logic          base_ok, go;
   logic [5:0]    k_sh;
   logic [PB-1:0] m2, cw_mask;
   logic          hi_ok;

   assign idx     = diff_ff[PAGE_SHIFT +: CW];
   assign idx_end = {1'b0, idx} + {1'b0, count_ff};
   assign base_ok = ready_ff && (count_ff != '0) && (count_ff <= usable_ff);
   assign k_sh    = shift_ff - PS6;
   assign m2      = ~({PB{1'b1}} << k_sh);
   assign cw_mask = {{(PB-CW){1'b0}}, {CW{1'b1}}};
   assign hi_ok   = (nb_ff & m2 & ~cw_mask) == '0;

   always_comb begin
      case (cmd_ff)
         CMD_ALLOC:       go = count_ff <= free_ff;
         CMD_ALLOC_ALIGN: go = 1'b1;
         CMD_FREE:        go = ge_ff && (diff_ff[63:PAGE_SHIFT+CW] == '0)
                               && (idx_end <= {1'b0, usable_ff});
         default:         go = 1'b0;
      endcase
      go = go && base_ok;
   end

   // ---- scan of one lane of pages
   logic [LANE_BITS-1:0] lane;
   logic                 s_have, s_hit, s_end;
   logic [CW-1:0]        s_c, s_len, s_start;

   assign lane = rd_data[{p_ff[WORD_LOG-1:LANE_LOG], {LANE_LOG{1'b0}}} +: LANE_BITS];

   always_comb begin
      logic [CW1-1:0] pk;
      s_have  = have_ff;
      s_c     = c_ff;
      s_len   = len_ff;
      s_hit   = 1'b0;
      s_end   = 1'b0;
      s_start = c_ff;
      for (int k = 0; k < LANE_BITS; k++) begin
         pk = {1'b0, p_ff} + CW1'(k);
         if (!s_hit && !s_end) begin
            if (pk >= {1'b0, usable_ff}) begin
               s_end = 1'b1;
            end else if (lane[k]) begin
               s_have = 1'b0;
               s_len  = '0;
            end else begin
               if (!s_have) begin
                  if (pre_ok_ff && (((pk[CW-1:0] ^ t_ff) & lmask_ff) == '0)) begin
                     s_have = 1'b1;
                     s_c    = pk[CW-1:0];
                     s_len  = CW'(1);
                  end
               end else begin
                  s_len = s_len + CW'(1);
               end
               if (s_have && (s_len == count_ff)) begin
                  s_hit   = 1'b1;
                  s_start = s_c;
               end
            end
         end
      end
   end

   // ---- run marking
   logic [CW-1:0]  m_e;
   logic [RAW-1:0] srow, erow;
   logic [5:0]     lo, hi;
   logic           mark_val;

   assign m_e      = ms_ff + count_ff - CW'(1);
   assign srow     = ms_ff[WORD_LOG +: RAW];
   assign erow     = m_e[WORD_LOG +: RAW];
   assign lo       = (r_ff == srow) ? ms_ff[WORD_LOG-1:0] : '0;
   assign hi       = (r_ff == erow) ? m_e[WORD_LOG-1:0] : '1;
   assign mark_val = cmd_ff != CMD_FREE;

   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         mask[i] = (6'(i) >= lo) && (6'(i) <= hi);
      end
   end

   assign merged  = mark_val ? (rd_data | mask) : (rd_data & ~mask);
   assign ram_wr  = cmd.clear_wr || cmd.mark_wr;
   assign ram_rd  = cmd.scan_rd || cmd.mark_rd;
   assign wr_data = cmd.clear_wr ? '0 : merged;
   assign rd_addr = cmd.mark_rd ? r_ff : p_ff[WORD_LOG +: RAW];

   bpa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (2**RAW),
      .AW    (RAW)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (r_ff),
      .wr_data (wr_data),
      .rd_en   (ram_rd),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---- heap size and free count
   logic [PB-1:0]  pages;
   logic           small_heap;
   logic [CW-1:0]  new_usable, free_next;
   logic [CW1-1:0] free_sum;
   logic [63:0]    addr_next;

   assign pages      = size_value[63:PAGE_SHIFT];
   assign small_heap = size_value < (64'(MIN_PAGES) << PAGE_SHIFT);
   assign new_usable = small_heap ? '0 :
                       (pages > PB'(MAX_PAGES)) ? CW'(MAX_PAGES) : pages[CW-1:0];
   assign free_sum   = {1'b0, free_ff} + {1'b0, count_ff};

   always_comb begin
      free_next = free_ff;
      addr_next = '0;
      if (cmd.rsp_ok) begin
         if (cmd_ff == CMD_FREE) begin
            free_next = (free_sum > {1'b0, usable_ff}) ? usable_ff : free_sum[CW-1:0];
         end else begin
            free_next = (free_ff >= count_ff) ? free_ff - count_ff : '0;
            addr_next = base_addr + (64'(ms_ff) << PAGE_SHIFT);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         usable_ff <= '0;
         free_ff   <= '0;
         ready_ff  <= 1'b0;
         r_ff      <= '0;
      end else begin
         if (size_wr) begin
            usable_ff <= new_usable;
            free_ff   <= new_usable;
            ready_ff  <= !small_heap;
         end else if (cmd.rsp_load) begin
            free_ff <= free_next;
         end
         if (cmd.clear_init) begin
            r_ff <= '0;
         end else if (cmd.clear_wr || cmd.mark_wr) begin
            r_ff <= r_ff + RAW'(1);
         end else if (cmd.check) begin
            r_ff <= idx[WORD_LOG +: RAW];
         end else if (cmd.scan_step && s_hit) begin
            r_ff <= s_start[WORD_LOG +: RAW];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff   <= req_command;
         count_ff <= CW'(req_page_count);
         shift_ff <= req_align_shift;
         faddr_ff <= req_free_addr;
      end
      if (cmd.prep) begin
         diff_ff   <= faddr_ff - base_addr;
         ge_ff     <= faddr_ff >= base_addr;
         nb_ff     <= PB'(0) - base_addr[63:PAGE_SHIFT];
         balign_ff <= (base_addr & ~({64{1'b1}} << ((shift_ff > PS6) ? PS6 : shift_ff)))
                      == '0;
      end
      if (cmd.check) begin
         ms_ff <= idx;
         if (cmd_ff == CMD_ALLOC_ALIGN) begin
            pre_ok_ff <= balign_ff && ((shift_ff <= PS6) || hi_ok);
            t_ff      <= nb_ff[CW-1:0];
            lmask_ff  <= (shift_ff > PS6) ? m2[CW-1:0] : '0;
         end else begin
            pre_ok_ff <= 1'b1;
            t_ff      <= '0;
            lmask_ff  <= '0;
         end
      end
      if (cmd.scan_init) begin
         p_ff    <= '0;
         have_ff <= 1'b0;
         len_ff  <= '0;
         c_ff    <= '0;
      end else if (cmd.scan_step) begin
         p_ff    <= p_ff + CW'(LANE_BITS);
         have_ff <= s_have;
         len_ff  <= s_len;
         c_ff    <= s_c;
         if (s_hit) begin
            ms_ff <= s_start;
         end
      end
      if (cmd.rsp_load) begin
         ok_ff   <= cmd.rsp_ok;
         addr_ff <= addr_next;
         pf_ff   <= free_next[12:0];
      end
   end

   assign status.clear_last     = r_ff == LAST_ROW;
   assign status.go             = go;
   assign status.go_free        = cmd_ff == CMD_FREE;
   assign status.scan_hit       = s_hit;
   assign status.scan_end       = s_end;
   assign status.scan_lane_last = p_ff[WORD_LOG-1:LANE_LOG] == '1;
   assign status.mark_last      = r_ff == erow;

   assign rsp_ok         = ok_ff;
   assign rsp_alloc_addr = addr_ff;
   assign rsp_pages_free = pf_ff;

   `BPA_ASSERT(a_free_le_usable, clock, reset, free_ff <= usable_ff)
   `BPA_ASSERT(a_size_sets_free, clock, reset, size_wr |=> (free_ff == usable_ff))
   `BPA_ASSERT(a_mark_in_heap, clock, reset, cmd.mark_wr |-> (m_e < usable_ff))
endmodule

[rtl/bitmap_page_allocator.sv]
// top level of the bitmap page allocator: csr port, controller and datapath
// depends on bpa_pkg, bpa_if, bpa_ctrl and bpa_dpath
`timescale 1ns / 1ps
// usage
//   req_chan takes one item per request: command, page_count, align_shift,
//   free_addr; rsp_chan returns one item per request, none for one that a
//   heap size write cuts off: ok, alloc_addr, pages_free, in request order
//   csr port: heap base address at byte 0, heap size at byte 8, 64-bit data
// cost per request, one request in flight at a time
//   fixed steps: latch, address terms, checks, result
//   first-fit scan: 8 pages a cycle plus one ram read per 64-page word,
//   repeated until the run is found or the heap ends
//   marking or freeing: a read and a write per bitmap word the run touches
//   a refused request takes only the fixed steps
// reset and heap size writes
//   the bitmap ram is swept to zero, one 64-page word a cycle
//   (MAX_PAGES/64 words, 64 at the default size); no item is taken meanwhile
// stalls
//   the result sits in an output register; the next item is accepted while
//   it waits, and only its own result holds until rsp_chan.ready
module bitmap_page_allocator import bpa_pkg::*; #(
   parameter int MAX_PAGES  = 4096,
   parameter int PAGE_SHIFT = 12,
   parameter int MIN_PAGES  = 16
) (
   input  logic              clock,
   input  logic              reset,
   bpa_req_if.sink           req_chan,
   bpa_rsp_if.source         rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [63:0]       csr_pwdata,
   output logic [63:0]       csr_prdata,
   output logic              csr_pready
);
   // configuration registers
   logic [63:0] base_ff, base_in;
   logic [63:0] size_ff, size_in;
   logic        csr_wr;
   logic        size_wr;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // write completes in the access phase; pready is tied high
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign size_wr    = csr_wr && (csr_paddr[CSR_IDX_BIT] == REG_SIZE);
   assign csr_prdata = (csr_paddr[CSR_IDX_BIT] == REG_SIZE) ? size_ff : base_ff;

   always_comb begin
      base_in = base_ff;
      size_in = size_ff;
      if (csr_wr) begin
         unique case (csr_paddr[CSR_IDX_BIT])
            REG_BASE: base_in = csr_pwdata;
            REG_SIZE: size_in = csr_pwdata;
            default:  base_in = base_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         size_ff <= '0;
      end else begin
         base_ff <= base_in;
         size_ff <= size_in;
      end
   end

   // sequencer: a heap size write restarts the clear sweep
   bpa_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .clear_start (size_wr),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .status      (status),
      .cmd         (cmd)
   );

   // bitmap, counters and result register
   bpa_dpath #(
      .MAX_PAGES  (MAX_PAGES),
      .PAGE_SHIFT (PAGE_SHIFT),
      .MIN_PAGES  (MIN_PAGES)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .base_addr       (base_ff),
      .size_wr         (size_wr),
      .size_value      (csr_pwdata),
      .req_command     (req_chan.command),
      .req_page_count  (req_chan.page_count),
      .req_align_shift (req_chan.align_shift),
      .req_free_addr   (req_chan.free_addr),
      .rsp_ok          (rsp_chan.ok),
      .rsp_alloc_addr  (rsp_chan.alloc_addr),
      .rsp_pages_free  (rsp_chan.pages_free)
   );
endmodule
